// ===== src/adt_pkg.sv =====
package adt_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int SENSOR_W = 16;
  localparam int ROW_W = SENSOR_COUNT * SENSOR_W;
  localparam int TOL_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int HISTORY_DEPTH_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_TOLERANCE = 2'd1;

  localparam logic signed [SENSOR_W-1:0] TARGET_TEMP_RST = 16'sd9523;
  localparam logic [TOL_W-1:0] BAND_TOLERANCE_RST = 15'd256;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_COOL = 2'd1,
    MODE_HEAT = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [SENSOR_W-1:0] average_temp;
    mode_e                      control_mode;
    logic                       heater_on;
    logic                       outside_vent_open;
    logic                       inside_vent_open;
    logic                       fans_on;
  } result_t;

endpackage

// ===== src/adt_history.sv =====
module adt_history
  import adt_pkg::*;
#(
  parameter int DEPTH = HISTORY_DEPTH_DEF,
  localparam int SLOT_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_slot_i,
  input  logic [ROW_W-1:0]  wr_data_i,
  output logic [ROW_W-1:0]  rd_data_o
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_q;
  logic [DEPTH-1:0] row_valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_slot_i];
    end
  end

  // A row that was never written reads as zero, which is its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_slot_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_slot_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== src/adt_mean_div.sv =====
module adt_mean_div
  import adt_pkg::*;
#(
  parameter int DEPTH = HISTORY_DEPTH_DEF,
  localparam int TOT_W = SENSOR_W + $clog2(SENSOR_COUNT * DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       load_u_i,
  input  logic signed [TOT_W-1:0]    total_i,
  input  logic                       load_p_i,
  output logic signed [SENSOR_W-1:0] average_o
);

  localparam int N = SENSOR_COUNT * DEPTH;
  localparam int L = $clog2(N);
  localparam int U_W = TOT_W;
  localparam int S = U_W + L;
  localparam int M_W = U_W + 1;
  localparam int P_W = U_W + M_W;
  localparam logic [U_W-1:0] OFFSET = U_W'(N) << (SENSOR_W - 1);
  localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << S) + 64'(N) - 64'd1) / 64'(N));

  logic [U_W-1:0]      u_q;
  logic [P_W-1:0]      prod_q;
  logic [SENSOR_W-1:0] quot;

  // The total is biased so that it is never negative; the floor quotient
  // of the biased total, less the bias over N, is the floor mean.
  always_ff @(posedge clk_i) begin
    if (load_u_i) begin
      u_q <= $unsigned(total_i) + OFFSET;
    end
    if (load_p_i) begin
      prod_q <= P_W'(u_q) * P_W'(RECIP);
    end
  end

  assign quot = prod_q[S +: SENSOR_W];
  assign average_o = $signed(quot ^ {1'b1, {(SENSOR_W-1){1'b0}}});

endmodule

// ===== src/adt_mode_ctl.sv =====
module adt_mode_ctl
  import adt_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic signed [SENSOR_W-1:0] average_i,
  input  logic signed [SENSOR_W-1:0] target_i,
  input  logic [TOL_W-1:0]           tolerance_i,
  output result_t                    result_o
);

  mode_e                     mode_q, mode_d;
  logic signed [SENSOR_W:0]  hi_lim, lo_lim, avg_ext;
  result_t                   result_d, result_q;

  assign avg_ext = {average_i[SENSOR_W-1], average_i};
  assign hi_lim  = $signed({target_i[SENSOR_W-1], target_i}) + $signed({2'b00, tolerance_i});
  assign lo_lim  = $signed({target_i[SENSOR_W-1], target_i}) - $signed({2'b00, tolerance_i});

  always_comb begin
    mode_d = mode_q;
    if (avg_ext > hi_lim) begin
      mode_d = MODE_COOL;
    end else if (avg_ext < lo_lim) begin
      mode_d = MODE_HEAT;
    end
  end

  always_comb begin
    result_d.average_temp = average_i;
    result_d.control_mode = mode_d;
    case (mode_d)
      MODE_COOL: begin
        result_d.heater_on         = 1'b0;
        result_d.outside_vent_open = 1'b1;
        result_d.inside_vent_open  = 1'b1;
        result_d.fans_on           = 1'b1;
      end
      MODE_HEAT: begin
        result_d.heater_on         = 1'b1;
        result_d.outside_vent_open = 1'b0;
        result_d.inside_vent_open  = 1'b1;
        result_d.fans_on           = 1'b1;
      end
      default: begin
        result_d.heater_on         = 1'b1;
        result_d.outside_vent_open = 1'b0;
        result_d.inside_vent_open  = 1'b0;
        result_d.fans_on           = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (load_i) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== src/averaged_deadband_thermostat.sv =====
// Averaged dead band thermostat.
// Input channel: in_valid_i with in_stall_o carries one word of four sensor
// temperatures in signed Q8.8 degrees C. A word is taken at a clock edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with out_stall_i carries one result word per
// input word: the floor mean of all stored readings, the held mode and the
// heater, vent and fan commands. A result is taken with out_valid_o high and
// out_stall_i low, and it holds steady while stalled.
// Configuration: cfg_valid_i with cfg_ready_o writes target_temp (index 0) or
// band_tolerance (index 1); other indexes are dropped. Write only while idle.
// Throughput is one word per cycle while the receiver does not stall. On
// its way from acceptance to out_valid_o a word has its history row read at
// acceptance, then passes the running total update with write back, the
// reciprocal multiply for the division, and the band compare.
// When the receiver stalls, words stay in the pipeline stages and the input
// keeps being taken until every stage is full; then in_stall_o rises.
// Reset clears the pipeline, the running total, the slot pointer and the held
// mode and loads the register defaults. History rows carry valid bits cleared
// by reset, so no clearing pass is needed and the block is ready at once.
module averaged_deadband_thermostat
  import adt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SENSOR_W-1:0] sensor_a_temp_i,
  input  logic signed [SENSOR_W-1:0] sensor_b_temp_i,
  input  logic signed [SENSOR_W-1:0] sensor_c_temp_i,
  input  logic signed [SENSOR_W-1:0] sensor_d_temp_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SENSOR_W-1:0] average_temp_o,
  output logic [1:0]                 control_mode_o,
  output logic                       heater_on_o,
  output logic                       outside_vent_open_o,
  output logic                       inside_vent_open_o,
  output logic                       fans_on_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SENSOR_W-1:0]        cfg_data_i
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int TOT_W = SENSOR_W + $clog2(SENSOR_COUNT * HISTORY_DEPTH);
  localparam int SUM_W = SENSOR_W + 2;

  // Configuration registers.
  logic signed [SENSOR_W-1:0] target_q;
  logic [TOL_W-1:0]           tolerance_q;

  // Pipeline occupancy.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_move, s2_move, s3_move;
  logic s1_free, s2_free, s3_free, out_free;
  logic in_accept;

  // First stage: the new readings wait here for the old row to come back.
  logic [ROW_W-1:0]         s1_row_q;
  logic signed [SUM_W-1:0]  s1_newsum_q;
  logic [SLOT_W-1:0]        s1_slot_q;
  logic [SLOT_W-1:0]        write_slot_q;
  logic signed [TOT_W-1:0]  total_q, total_d;
  logic [ROW_W-1:0]         old_row;
  logic signed [SUM_W-1:0]  new_sum, old_sum;
  logic signed [SENSOR_W-1:0] average;
  result_t                  result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_TEMP_RST;
      tolerance_q <= BAND_TOLERANCE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TARGET_TEMP) begin
        target_q <= $signed(cfg_data_i);
      end else if (cfg_index_i == CFG_BAND_TOLERANCE) begin
        tolerance_q <= cfg_data_i[TOL_W-1:0];
      end
    end
  end

  // Each stage advances when the one ahead of it is empty or advancing too.
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s3_move   = s3_valid_q && out_free;
  assign s3_free   = !s3_valid_q || s3_move;
  assign s2_move   = s2_valid_q && s3_free;
  assign s2_free   = !s2_valid_q || s2_move;
  assign s1_move   = s1_valid_q && s2_free;
  assign s1_free   = !s1_valid_q || s1_move;
  assign in_accept = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept || (s1_valid_q && !s1_move);
      s2_valid_q  <= s1_move || (s2_valid_q && !s2_move);
      s3_valid_q  <= s2_move || (s3_valid_q && !s3_move);
      out_valid_q <= s3_move || (out_valid_q && out_stall_i);
    end
  end

  assign new_sum = SUM_W'(sensor_a_temp_i) + SUM_W'(sensor_b_temp_i)
                 + SUM_W'(sensor_c_temp_i) + SUM_W'(sensor_d_temp_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_row_q    <= {sensor_d_temp_i, sensor_c_temp_i, sensor_b_temp_i, sensor_a_temp_i};
      s1_newsum_q <= new_sum;
      s1_slot_q   <= write_slot_q;
    end
  end

  // The slot pointer moves at acceptance; the total moves when the old row
  // has been read and the new one is written back in its place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      total_q      <= '0;
    end else begin
      if (in_accept) begin
        if (write_slot_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
          write_slot_q <= '0;
        end else begin
          write_slot_q <= write_slot_q + 1'b1;
        end
      end
      if (s1_move) begin
        total_q <= total_d;
      end
    end
  end

  assign old_sum = SUM_W'($signed(old_row[0*SENSOR_W +: SENSOR_W]))
                 + SUM_W'($signed(old_row[1*SENSOR_W +: SENSOR_W]))
                 + SUM_W'($signed(old_row[2*SENSOR_W +: SENSOR_W]))
                 + SUM_W'($signed(old_row[3*SENSOR_W +: SENSOR_W]));
  assign total_d = total_q + TOT_W'(s1_newsum_q) - TOT_W'(old_sum);

  adt_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_slot_i (write_slot_q),
    .wr_en_i   (s1_move),
    .wr_slot_i (s1_slot_q),
    .wr_data_i (s1_row_q),
    .rd_data_o (old_row)
  );

  adt_mean_div #(
    .DEPTH (HISTORY_DEPTH)
  ) u_mean_div (
    .clk_i     (clk_i),
    .load_u_i  (s1_move),
    .total_i   (total_d),
    .load_p_i  (s2_move),
    .average_o (average)
  );

  adt_mode_ctl u_mode_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s3_move),
    .average_i   (average),
    .target_i    (target_q),
    .tolerance_i (tolerance_q),
    .result_o    (result)
  );

  assign out_valid_o         = out_valid_q;
  assign average_temp_o      = result.average_temp;
  assign control_mode_o      = result.control_mode;
  assign heater_on_o         = result.heater_on;
  assign outside_vent_open_o = result.outside_vent_open;
  assign inside_vent_open_o  = result.inside_vent_open;
  assign fans_on_o           = result.fans_on;

endmodule

// ===== src/adt_checker.sv =====
module adt_checker
  import adt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SENSOR_W-1:0] average_temp_o,
  input logic [1:0]          control_mode_o,
  input logic                heater_on_o,
  input logic                outside_vent_open_o,
  input logic                inside_vent_open_o,
  input logic                fans_on_o
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // The commands of every offered word agree with the reported mode.
  a_cool_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && control_mode_o == MODE_COOL |->
      !heater_on_o && outside_vent_open_o && inside_vent_open_o && fans_on_o)
    else $error("cooling commands inconsistent");

  a_idle_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (control_mode_o == MODE_NONE || control_mode_o == MODE_HEAT) |->
      heater_on_o && !outside_vent_open_o && (inside_vent_open_o == fans_on_o)
      && (fans_on_o == (control_mode_o == MODE_HEAT)))
    else $error("heating or idle commands inconsistent");

  // Once reset has been seen at a clock edge, nothing is offered in the
  // following cycle.
  a_reset_quiet: assert property (@(posedge clk_i)
      !rst_ni |=> !out_valid_o)
    else $error("result offered right after reset");

  // The mean changes only when a word is taken or none is offered.
  a_avg_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> $stable(average_temp_o))
    else $error("stalled mean changed");

endmodule

bind averaged_deadband_thermostat adt_checker u_adt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .average_temp_o      (average_temp_o),
  .control_mode_o      (control_mode_o),
  .heater_on_o         (heater_on_o),
  .outside_vent_open_o (outside_vent_open_o),
  .inside_vent_open_o  (inside_vent_open_o),
  .fans_on_o           (fans_on_o)
);

// ===== dv/averaged_deadband_thermostat_test.sv =====
module averaged_deadband_thermostat_test;
  timeunit 1ns;
  timeprecision 1ps;
  import adt_pkg::*;

  // The bench runs in two parts. A short directed table comes first. Its
  // rows either program the band registers, or send one word whose result is
  // typed in by hand, or send one word that the climate predictor checks.
  // Random phases follow, each under its own band setting and its own
  // pacing on both channels. Every accepted result word is compared field by
  // field with the oldest predicted word.

  localparam int CLK_PERIOD     = 20;
  localparam int AVG_SHIFT      = $clog2(SENSOR_COUNT * HISTORY_DEPTH_DEF);
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 170;
  localparam int SEGMENT_WORDS  = 24;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SENSOR_MAX     = 32767;
  localparam int SENSOR_MIN     = -32768;

  // Indexes past the two registers; the block must drop writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_e;

  typedef enum logic [1:0] {
    SEG_UNIFORM,
    SEG_FOCUS,
    SEG_CORNER
  } segment_e;

  typedef enum logic [1:0] {
    ROW_BAND,
    ROW_TYPED,
    ROW_CHECKED
  } row_kind_e;

  typedef logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] temps_t;

  typedef struct {
    row_kind_e        kind;
    logic [15:0]      target;
    logic [TOL_W-1:0] tol;
    temps_t           temps;
    result_t          want;
  } climate_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SENSOR_W-1:0] sensor_a_temp_i = '0;
  logic signed [SENSOR_W-1:0] sensor_b_temp_i = '0;
  logic signed [SENSOR_W-1:0] sensor_c_temp_i = '0;
  logic signed [SENSOR_W-1:0] sensor_d_temp_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SENSOR_W-1:0] average_temp_o;
  logic [1:0]                 control_mode_o;
  logic                       heater_on_o;
  logic                       outside_vent_open_o;
  logic                       inside_vent_open_o;
  logic                       fans_on_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [SENSOR_W-1:0]        cfg_data_i = '0;

  averaged_deadband_thermostat u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sensor_a_temp_i     (sensor_a_temp_i),
    .sensor_b_temp_i     (sensor_b_temp_i),
    .sensor_c_temp_i     (sensor_c_temp_i),
    .sensor_d_temp_i     (sensor_d_temp_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .average_temp_o      (average_temp_o),
    .control_mode_o      (control_mode_o),
    .heater_on_o         (heater_on_o),
    .outside_vent_open_o (outside_vent_open_o),
    .inside_vent_open_o  (inside_vent_open_o),
    .fans_on_o           (fans_on_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the block's state. It starts at the reset values and
  // follows every accepted register write and input word.
  logic signed [SENSOR_W-1:0] history [HISTORY_DEPTH_DEF][SENSOR_COUNT];
  int                         slot = 0;
  int                         running_sum = 0;
  mode_e                      held_mode = MODE_NONE;
  logic signed [SENSOR_W-1:0] set_point = TARGET_TEMP_RST;
  logic [TOL_W-1:0]           band_half = BAND_TOLERANCE_RST;

  result_t expected_readouts[$];
  int      failures = 0;

  // Pacing of the two channels. The sender runs in bursts with idle gaps
  // between them; the receiver stalls according to stall_mode.
  stall_e stall_mode = STALL_NONE;
  int     gap_max = 0;
  int     burst_left = 1;
  int     stall_tick = 0;
  int     idle_cycles = 0;

  // One input word moves the history ring by one slot. The running sum
  // always covers all stored readings, so the mean is a floor shift of it.
  // A mean sitting exactly on a band limit keeps the held mode.
  function automatic result_t step_climate(input temps_t temps);
    result_t r;
    int      avg;
    int      hi_lim;
    int      lo_lim;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      running_sum += int'($signed(temps[s])) - int'(history[slot][s]);
      history[slot][s] = temps[s];
    end
    slot = (slot + 1) % HISTORY_DEPTH_DEF;
    avg = running_sum >>> AVG_SHIFT;
    // The limits are formed as int, so they never wrap at 16 bits.
    hi_lim = int'(set_point) + int'(band_half);
    lo_lim = int'(set_point) - int'(band_half);
    if (avg > hi_lim) begin
      held_mode = MODE_COOL;
    end else if (avg < lo_lim) begin
      held_mode = MODE_HEAT;
    end
    r.average_temp      = avg[SENSOR_W-1:0];
    r.control_mode      = held_mode;
    // The heater is on after reset and stays on until cooling is commanded.
    r.heater_on         = (held_mode != MODE_COOL);
    r.outside_vent_open = (held_mode == MODE_COOL);
    r.inside_vent_open  = (held_mode != MODE_NONE);
    r.fans_on           = (held_mode != MODE_NONE);
    return r;
  endfunction

  function automatic climate_row_t band_row(input logic [15:0] target,
                                            input logic [TOL_W-1:0] tol);
    climate_row_t r;
    r = '{kind: ROW_BAND, target: target, tol: tol, temps: '0, want: '0};
    return r;
  endfunction

  // All four sensors read v; the result word is given in full.
  function automatic climate_row_t typed_row(input logic [15:0] v,
                                             input logic signed [15:0] avg,
                                             input mode_e m,
                                             input logic heat, input logic out_vent,
                                             input logic in_vent, input logic fans);
    climate_row_t r;
    r = '{kind: ROW_TYPED, target: '0, tol: '0, temps: {SENSOR_COUNT{v}}, want: '0};
    r.want = '{avg, m, heat, out_vent, in_vent, fans};
    return r;
  endfunction

  function automatic climate_row_t checked_row(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] c, input logic [15:0] d);
    climate_row_t r;
    r = '{kind: ROW_CHECKED, target: '0, tol: '0, temps: {d, c, b, a}, want: '0};
    return r;
  endfunction

  // Holds the word on the bus until the block takes it, then files the
  // expected result. Valid is left high so that a burst can continue.
  task automatic send_word(input temps_t temps, input bit use_typed, input result_t typed);
    result_t pred;
    sensor_a_temp_i <= temps[0];
    sensor_b_temp_i <= temps[1];
    sensor_c_temp_i <= temps[2];
    sensor_d_temp_i <= temps[3];
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = step_climate(temps);
    expected_readouts.push_back(use_typed ? typed : pred);
  endtask

  // Decides, after each accepted word, whether the burst goes on. Valid is
  // lowered only here, so it gets one assignment per clock edge at most.
  task automatic after_word(input bit last_of_phase);
    burst_left--;
    if (last_of_phase) begin
      in_valid_i <= 1'b0;
    end else if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TARGET_TEMP:    set_point = data;
      CFG_BAND_TOLERANCE: band_half = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  // Every result carries one word per input, so an empty store means the
  // pipeline holds nothing; a few more cycles are allowed all the same.
  task automatic wait_drained();
    while (expected_readouts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Rewrites both band registers while the block is idle. The spare
  // indexes get junk, and the unused top bit of the tolerance word is
  // random too; neither may change anything.
  task automatic program_band(input logic [15:0] target, input logic [TOL_W-1:0] tol);
    wait_drained();
    write_register(CFG_TARGET_TEMP, target);
    write_register(CFG_SPARE_2, 16'($urandom));
    write_register(CFG_BAND_TOLERANCE, {1'($urandom), tol});
    write_register(CFG_SPARE_3, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  // Receiver side: the stall pattern runs on its own, apart from the sender.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= ((stall_tick % 11) < 4);
      default:        out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin : check_readout
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readouts.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual average %0d mode %0d",
                 $time, average_temp_o, control_mode_o);
        failures++;
      end else begin
        want = expected_readouts.pop_front();
        check_field("average_temp", int'(want.average_temp), int'(average_temp_o));
        check_field("control_mode", int'(want.control_mode), int'(control_mode_o));
        check_field("heater_on", int'(want.heater_on), int'(heater_on_o));
        check_field("outside_vent_open", int'(want.outside_vent_open),
                    int'(outside_vent_open_o));
        check_field("inside_vent_open", int'(want.inside_vent_open),
                    int'(inside_vent_open_o));
        check_field("fans_on", int'(want.fans_on), int'(fans_on_o));
      end
    end
  end

  // The watchdog counts cycles in which no word moves on any channel. The
  // longest quiet stretch of a correct run is a sender gap, a stall run or
  // the settle time before a register write, all far below the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    climate_row_t     plan[$];
    temps_t           temps;
    segment_e         style;
    logic [15:0]      target;
    logic [TOL_W-1:0] tol;
    bit               quiet;
    int               focus;
    int               val;
    int               lo_lim;
    int               hi_lim;
    int               pick;

    for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        history[i][s] = '0;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni     <= 1'b1;
    stall_mode <= STALL_LIGHT;
    gap_max    = 3;
    burst_left = 4;

    // With the target left at its reset value, a tolerance of the same size
    // puts the lower limit at exactly zero. An all zero first word then lands
    // on that limit, so no command is given yet and the outputs keep their
    // reset look: heater on, vents closed, fans off.
    write_register(CFG_BAND_TOLERANCE, 16'd9523);
    cfg_valid_i <= 1'b0;

    // Warm up: the zero history pulls the first means toward zero. The
    // third word brings the sum to -4, whose floor mean is -1, just under
    // the lower limit, so heating starts.
    plan.push_back(typed_row(16'h0000, 16'sd0, MODE_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(typed_row(16'h7fff, 16'sd2047, MODE_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(typed_row(16'h8000, -16'sd1, MODE_HEAT, 1'b1, 1'b0, 1'b1, 1'b1));
    // Band of +/-1.0 C around zero: full scale cools, a mean of -1 holds,
    // and the next full negative word heats with floor rounding to -2049.
    plan.push_back(band_row(16'h0000, 15'd256));
    plan.push_back(typed_row(16'h7fff, 16'sd2047, MODE_COOL, 1'b0, 1'b1, 1'b1, 1'b1));
    plan.push_back(typed_row(16'h8000, -16'sd1, MODE_COOL, 1'b0, 1'b1, 1'b1, 1'b1));
    plan.push_back(typed_row(16'h8000, -16'sd2049, MODE_HEAT, 1'b1, 1'b0, 1'b1, 1'b1));
    plan.push_back(checked_row(16'h7fff, 16'h8000, 16'h0000, 16'hffff));
    plan.push_back(checked_row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    plan.push_back(checked_row(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    plan.push_back(checked_row(16'h0001, 16'h0002, 16'h0004, 16'h0008));
    // Widest band at the bottom of the target range: the lower limit sits
    // far below anything a 16 bit mean can reach.
    plan.push_back(band_row(16'h8000, 15'h7fff));
    plan.push_back(checked_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    plan.push_back(checked_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    // Widest band at the top of the target range.
    plan.push_back(band_row(16'h7fff, 15'h7fff));
    plan.push_back(checked_row(16'h0100, 16'h0200, 16'h0400, 16'h0800));
    plan.push_back(checked_row(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    // Zero tolerance: both limits coincide with the target.
    plan.push_back(band_row(16'h0000, 15'd0));
    plan.push_back(checked_row(16'h1000, 16'h2000, 16'h4000, 16'h8000));
    plan.push_back(checked_row(16'hfffe, 16'hfffd, 16'hfffb, 16'hfff7));
    plan.push_back(checked_row(16'h0000, 16'h0000, 16'h0000, 16'h0000));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_BAND) begin
        program_band(plan[i].target, plan[i].tol);
      end else begin
        send_word(plan[i].temps, plan[i].kind == ROW_TYPED, plan[i].want);
        after_word(i == plan.size() - 1 || plan[i + 1].kind == ROW_BAND);
      end
    end

    // Random phases. Each one sets the band, the stall pattern and the gap
    // length, so that idling falls on every stage of the pipeline. Phase 4
    // runs with no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin target = TARGET_TEMP_RST; tol = BAND_TOLERANCE_RST; end
        1: begin target = 16'h7fff; tol = 15'h7fff; end
        2: begin target = 16'h8000; tol = 15'h7fff; end
        3: begin target = 16'($urandom); tol = '0; end
        4: begin target = '0; tol = '0; end
        5: begin target = 16'h8000; tol = '0; end
        6: begin target = 16'h7fff; tol = '0; end
        default: begin target = 16'($urandom); tol = TOL_W'($urandom); end
      endcase
      program_band(target, tol);
      stall_mode <= stall_e'(p % 4);
      gap_max    = (p == 4) ? 0 : 2 + 3 * (p % 3);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Segments are long enough to refill the whole history, so a quiet
        // focus segment drives the mean exactly onto a limit, next to it or onto the target.
        if (n % SEGMENT_WORDS == 0) begin
          pick = $urandom_range(0, 9);
          style = (pick < 4) ? SEG_UNIFORM : (pick < 8) ? SEG_FOCUS : SEG_CORNER;
          quiet = $urandom_range(0, 1);
          lo_lim = int'(set_point) - int'(band_half);
          hi_lim = int'(set_point) + int'(band_half);
          case ($urandom_range(0, 4))
            0: focus = lo_lim - 1;
            1: focus = lo_lim;
            2: focus = hi_lim;
            3: focus = hi_lim + 1;
            default: focus = int'(set_point);
          endcase
        end
        for (int s = 0; s < SENSOR_COUNT; s++) begin
          case (style)
            SEG_UNIFORM: temps[s] = 16'($urandom);
            SEG_FOCUS: begin
              val = quiet ? focus : focus + int'($urandom_range(0, 64)) - 32;
              if (val > SENSOR_MAX) begin
                val = SENSOR_MAX;
              end else if (val < SENSOR_MIN) begin
                val = SENSOR_MIN;
              end
              temps[s] = val[SENSOR_W-1:0];
            end
            default: begin
              case ($urandom_range(0, 4))
                0: temps[s] = 16'h7fff;
                1: temps[s] = 16'h8000;
                2: temps[s] = 16'h0000;
                3: temps[s] = 16'hffff;
                default: temps[s] = 16'h0001;
              endcase
            end
          endcase
        end
        send_word(temps, 1'b0, '0);
        after_word(n == PHASE_WORDS - 1);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_readouts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/adt_pkg.sv
src/adt_history.sv
src/adt_mean_div.sv
src/adt_mode_ctl.sv
src/averaged_deadband_thermostat.sv
src/adt_checker.sv
dv/averaged_deadband_thermostat_test.sv
